@@ hw/rtl/esi_pkg.sv @@
package esi_pkg;

    localparam int MAX_EXPIRIES_DEF = 16;
    localparam int MAX_STRIKES_DEF  = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NODATA  = 3'd1;
    localparam logic [2:0] STAT_NEGTIME = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_DUP     = 3'd4;

    // round(mag_a * mag_b / den), clamped to 2^40
    typedef struct packed {
        logic        start;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] den;
    } t_mdu_req;

    typedef struct packed {
        logic        done;
        logic [40:0] quo;
    } t_mdu_rsp;

endpackage

@@ hw/rtl/esi_mdu.sv @@
module esi_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esi_pkg::t_mdu_req i_req,
    output esi_pkg::t_mdu_rsp o_rsp
);

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_MUL  = 5'b00010,
        U_ADD  = 5'b00100,
        U_DIV  = 5'b01000,
        U_FIN  = 5'b10000
    } t_ustate;

    t_ustate     r_state;
    logic [63:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_acc;
    logic [31:0] r_den;
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;

    logic [32:0] rem2;
    logic        ge;

    assign rem2 = {r_rem, r_num[63]};
    assign ge   = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_ma    <= {32'd0, i_req.mag_a};
                        r_mb    <= i_req.mag_b;
                        r_acc   <= '0;
                        r_den   <= i_req.den;
                        r_cnt   <= '0;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma  <= {r_ma[62:0], 1'b0};
                    r_mb  <= {1'b0, r_mb[31:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_state <= U_ADD;
                    end
                end
                U_ADD: begin
                    // add half the divisor for round to nearest
                    r_num   <= r_acc + {33'd0, r_den[31:1]};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    r_num <= {r_num[62:0], ge};
                    r_rem <= ge ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.done = (r_state == U_FIN);
    assign o_rsp.quo  = (r_num > 64'h0000_0100_0000_0000) ? 41'h100_0000_0000 : r_num[40:0];

endmodule

@@ hw/rtl/expiry_strike_surface_interpolator_top.sv @@
// Load: row scan, strike scan, insert shift.
// Query: each of the three scaled divisions
// runs through the shared multiply-divide unit, 32 multiply steps plus 64 divide steps.
// Throughput: one transaction at a time; input ready only while the sequencer is idle.
// Reset (synchronous, active low) empties the table; stored entries keep their contents.
module expiry_strike_surface_interpolator_top #(
    parameter int MAX_EXPIRIES = esi_pkg::MAX_EXPIRIES_DEF,
    parameter int MAX_STRIKES  = esi_pkg::MAX_STRIKES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_time_req,
    input  logic signed [31:0] i_strike,
    input  logic signed [31:0] i_value_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result_value,
    output logic [2:0]         o_status
);

    localparam int EW    = (MAX_EXPIRIES > 1) ? $clog2(MAX_EXPIRIES) : 1;
    localparam int SW    = (MAX_STRIKES > 1) ? $clog2(MAX_STRIKES) : 1;
    localparam int RCW   = $clog2(MAX_EXPIRIES + 1);
    localparam int CW    = $clog2(MAX_STRIKES + 1);
    localparam int AW    = EW + SW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LSCAN = 12'b000000000010,
        S_QSCAN = 12'b000000000100,
        S_RD    = 12'b000000001000,
        S_CHK   = 12'b000000010000,
        S_LFULL = 12'b000000100000,
        S_SHRD  = 12'b000001000000,
        S_SHWR  = 12'b000010000000,
        S_INS   = 12'b000100000000,
        S_ROWV  = 12'b001000000000,
        S_MUL   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state             r_state;
    logic [RCW-1:0]     r_rc;
    logic [CW-1:0]      r_cnt [MAX_EXPIRIES];
    logic signed [31:0] r_rtime [MAX_EXPIRIES];
    logic [EW-1:0]      r_map [MAX_EXPIRIES];

    logic signed [31:0] r_strike_mem [DEPTH];
    logic signed [31:0] r_value_mem [DEPTH];
    logic signed [31:0] r_rd_s;
    logic signed [31:0] r_rd_v;

    logic [1:0]         r_req;
    logic signed [31:0] r_t;
    logic signed [31:0] r_k;
    logic signed [31:0] r_val;
    logic [RCW-1:0]     r_ri;
    logic [EW-1:0]      r_phys;
    logic [CW-1:0]      r_m;
    logic [CW-1:0]      r_pos;
    logic               r_new;
    logic               r_tz;
    logic               r_single;
    logic               r_second;
    logic               r_tphase;
    logic signed [31:0] r_s_prev;
    logic signed [31:0] r_v_prev;
    logic signed [31:0] r_rt_lo;
    logic signed [31:0] r_rt_hi;
    logic [EW-1:0]      r_ph_hi;
    logic signed [31:0] r_y;
    logic signed [31:0] r_y1;
    logic signed [31:0] r_base;
    logic               r_neg;
    logic               r_go;
    logic [31:0]        r_mag_a;
    logic [31:0]        r_mag_b;
    logic [31:0]        r_den;
    logic signed [31:0] r_res;
    logic [2:0]         r_st;
    logic               r_ov;
    logic signed [31:0] r_out_res;
    logic [2:0]         r_out_st;

    logic signed [31:0] rt_sel;
    logic [EW-1:0]      map_sel;
    logic [CW-1:0]      cnt_cur;
    logic [CW-1:0]      rd_slot;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CW-1:0]      wr_slot;
    logic signed [31:0] wr_s;
    logic signed [31:0] wr_v;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [32:0] op_d;
    logic signed [42:0] sum;
    logic signed [42:0] base43;
    logic signed [42:0] quo43;
    logic signed [31:0] sat;

    esi_pkg::t_mdu_req  mdu_req;
    esi_pkg::t_mdu_rsp  mdu_rsp;

    function automatic logic [31:0] mag33(input logic signed [32:0] x);
        logic [32:0] nx;
        nx = 33'(-x);
        return x[32] ? nx[31:0] : x[31:0];
    endfunction

    assign map_sel = r_map[r_ri[EW-1:0]];
    assign rt_sel  = r_rtime[map_sel];
    assign cnt_cur = r_cnt[r_phys];

    // shift reads one slot below the write slot
    assign rd_slot = (r_state == S_SHRD) ? r_m - CW'(1) : r_m;
    assign rd_addr = {r_phys, rd_slot[SW-1:0]};
    assign wr_en   = (r_state == S_SHWR) || (r_state == S_INS);
    assign wr_slot = (r_state == S_INS) ? r_pos : r_m;
    assign wr_addr = {r_phys, wr_slot[SW-1:0]};
    assign wr_s    = (r_state == S_INS) ? r_k : r_rd_s;
    assign wr_v    = (r_state == S_INS) ? r_val : r_rd_v;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_strike_mem[wr_addr] <= wr_s;
            r_value_mem[wr_addr]  <= wr_v;
        end
        r_rd_s <= r_strike_mem[rd_addr];
        r_rd_v <= r_value_mem[rd_addr];
    end

    // operands: time step in S_ROWV, strike step otherwise
    always_comb begin
        if (r_state == S_ROWV) begin
            op_a = 33'(r_y) - 33'(r_y1);
            op_b = 33'(r_t) - 33'(r_rt_lo);
            op_d = 33'(r_rt_hi) - 33'(r_rt_lo);
        end else begin
            op_a = 33'(r_rd_v) - 33'(r_v_prev);
            op_b = 33'(r_k) - 33'(r_s_prev);
            op_d = 33'(r_rd_s) - 33'(r_s_prev);
        end
    end

    assign mdu_req.start = r_go;
    assign mdu_req.mag_a = r_mag_a;
    assign mdu_req.mag_b = r_mag_b;
    assign mdu_req.den   = r_den;

    esi_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .o_rsp   (mdu_rsp)
    );

    assign base43 = 43'(r_base);
    assign quo43  = {2'b00, mdu_rsp.quo};
    assign sum    = r_neg ? base43 - quo43 : base43 + quo43;

    always_comb begin
        if (sum > 43'sd2147483647) begin
            sat = 32'sh7fff_ffff;
        end else if (sum < -43'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rc    <= '0;
            r_ov    <= 1'b0;
            r_go    <= 1'b0;
            for (int i = 0; i < MAX_EXPIRIES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_go <= 1'b0;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req    <= i_req_type;
                        r_t      <= i_time_req;
                        r_k      <= i_strike;
                        r_val    <= i_value_in;
                        r_res    <= '0;
                        r_st     <= esi_pkg::STAT_OK;
                        r_tz     <= 1'b0;
                        r_single <= 1'b0;
                        r_second <= 1'b0;
                        r_tphase <= 1'b0;
                        r_new    <= 1'b0;
                        r_ri     <= '0;
                        r_m      <= '0;
                        if (i_req_type == esi_pkg::REQ_LOAD) begin
                            if (i_time_req < 0) begin
                                r_st    <= esi_pkg::STAT_NEGTIME;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_LSCAN;
                            end
                        end else if (i_req_type == esi_pkg::REQ_QUERY) begin
                            if (r_rc == '0) begin
                                r_st    <= esi_pkg::STAT_NODATA;
                                r_state <= S_DONE;
                            end else if (i_time_req < 0) begin
                                r_st    <= esi_pkg::STAT_NEGTIME;
                                r_state <= S_DONE;
                            end else if (i_time_req == 0) begin
                                r_tz    <= 1'b1;
                                r_phys  <= r_map[0];
                                r_state <= S_RD;
                            end else if (r_rc == RCW'(1)) begin
                                r_single <= 1'b1;
                                r_phys   <= r_map[0];
                                r_state  <= S_RD;
                            end else begin
                                r_state <= S_QSCAN;
                            end
                        end else begin
                            if (i_req_type == esi_pkg::REQ_CLEAR) begin
                                r_rc <= '0;
                                for (int i = 0; i < MAX_EXPIRIES; i++) begin
                                    r_cnt[i] <= '0;
                                end
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LSCAN: begin
                    if (r_ri < r_rc && rt_sel < r_t) begin
                        r_ri <= r_ri + RCW'(1);
                    end else if (r_ri < r_rc && rt_sel == r_t) begin
                        r_phys  <= map_sel;
                        r_state <= S_RD;
                    end else if (r_rc >= RCW'(MAX_EXPIRIES)) begin
                        r_st    <= esi_pkg::STAT_FULL;
                        r_state <= S_DONE;
                    end else begin
                        // new row takes the next free slot
                        r_new   <= 1'b1;
                        r_phys  <= r_rc[EW-1:0];
                        r_pos   <= '0;
                        r_state <= S_INS;
                    end
                end
                S_QSCAN: begin
                    r_rt_lo <= r_rt_hi;
                    r_rt_hi <= rt_sel;
                    r_ph_hi <= map_sel;
                    if (r_ri == '0) begin
                        r_ri <= RCW'(1);
                    end else if (r_ri < r_rc - RCW'(1) && rt_sel < r_t) begin
                        r_ri <= r_ri + RCW'(1);
                    end else begin
                        r_phys  <= r_ph_hi;
                        r_m     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_tz) begin
                        r_res   <= r_rd_v;
                        r_state <= S_DONE;
                    end else if (r_req == esi_pkg::REQ_LOAD) begin
                        if (r_rd_s == r_k) begin
                            r_st    <= esi_pkg::STAT_DUP;
                            r_state <= S_DONE;
                        end else if (r_rd_s > r_k) begin
                            r_pos   <= r_m;
                            r_state <= S_LFULL;
                        end else if (r_m + CW'(1) == cnt_cur) begin
                            r_pos   <= cnt_cur;
                            r_state <= S_LFULL;
                        end else begin
                            r_m     <= r_m + CW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        if (r_rd_s > r_k) begin
                            if (r_m == '0) begin
                                r_y     <= r_rd_v;
                                r_state <= S_ROWV;
                            end else begin
                                r_go    <= 1'b1;
                                r_mag_a <= mag33(op_a);
                                r_mag_b <= mag33(op_b);
                                r_den   <= op_d[31:0];
                                r_neg   <= op_a[32] != op_b[32];
                                r_base  <= r_v_prev;
                                r_state <= S_MUL;
                            end
                        end else if (r_m + CW'(1) == cnt_cur) begin
                            // at or past the top strike: hold flat
                            r_y     <= r_rd_v;
                            r_state <= S_ROWV;
                        end else begin
                            r_s_prev <= r_rd_s;
                            r_v_prev <= r_rd_v;
                            r_m      <= r_m + CW'(1);
                            r_state  <= S_RD;
                        end
                    end
                end
                S_LFULL: begin
                    if (cnt_cur >= CW'(MAX_STRIKES)) begin
                        r_st    <= esi_pkg::STAT_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_m     <= cnt_cur;
                        r_state <= S_SHRD;
                    end
                end
                S_SHRD: begin
                    if (r_m == r_pos) begin
                        r_state <= S_INS;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_m     <= r_m - CW'(1);
                    r_state <= S_SHRD;
                end
                S_INS: begin
                    r_cnt[r_phys] <= r_new ? CW'(1) : cnt_cur + CW'(1);
                    if (r_new) begin
                        r_rtime[r_phys] <= r_t;
                        r_rc            <= r_rc + RCW'(1);
                        for (int i = 1; i < MAX_EXPIRIES; i++) begin
                            if (RCW'(i) > r_ri && RCW'(i) <= r_rc) begin
                                r_map[i] <= r_map[i-1];
                            end
                        end
                        for (int i = 0; i < MAX_EXPIRIES; i++) begin
                            if (RCW'(i) == r_ri) begin
                                r_map[i] <= r_rc[EW-1:0];
                            end
                        end
                    end
                    r_state <= S_DONE;
                end
                S_ROWV: begin
                    if (r_single) begin
                        r_res   <= r_y;
                        r_state <= S_DONE;
                    end else if (!r_second) begin
                        r_y1     <= r_y;
                        r_second <= 1'b1;
                        r_phys   <= r_ph_hi;
                        r_m      <= '0;
                        r_state  <= S_RD;
                    end else begin
                        r_go     <= 1'b1;
                        r_mag_a  <= mag33(op_a);
                        r_mag_b  <= mag33(op_b);
                        r_den    <= op_d[31:0];
                        r_neg    <= op_a[32] != op_b[32];
                        r_base   <= r_y1;
                        r_tphase <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mdu_rsp.done) begin
                        if (r_tphase) begin
                            r_res   <= sat;
                            r_state <= S_DONE;
                        end else begin
                            r_y     <= sum[31:0];
                            r_state <= S_ROWV;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_ready) begin
                        r_ov      <= 1'b1;
                        r_out_res <= r_res;
                        r_out_st  <= r_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_st;

endmodule
